// File: hw/rtl/vtr_pkg.sv
// ----------------------------------------------------------------------------
// vtr_pkg: shared types and constants for the visible tile range unit
// Widths of fields and internal pipeline words, register indexes, latency.
// ----------------------------------------------------------------------------
package vtr_pkg;

    localparam int CoordW   = 24;  // signed center
    localparam int SizeW    = 23;  // unsigned viewport size
    localparam int CfgW     = 16;  // every register
    localparam int CountW   = 17;  // signed count
    localparam int TwoTileW = 17;  // tile scaled by two
    localparam int Num1W    = 26;  // first dividend (edge magnitude)
    localparam int Num2W    = 25;  // second dividend (count numerator)
    localparam int WideW    = 28;  // clipping arithmetic
    localparam int StartW   = 27;  // signed start tile

    // Register stages through one axis pipe: entry, first divider,
    // remainder fixup, second divider, two clip stages.
    localparam int AxisLat = 1 + Num1W + 1 + Num2W + 2;

    typedef enum logic [1:0] {
        REG_TILE_WIDTH   = 2'd0,
        REG_TILE_HEIGHT  = 2'd1,
        REG_GRID_COLUMNS = 2'd2,
        REG_GRID_ROWS    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic                     beyond;
        logic [CfgW-1:0]          first;
        logic signed [CountW-1:0] count;
    } axis_res_t;

endpackage

// File: hw/rtl/vtr_axis.sv
// ----------------------------------------------------------------------------
// vtr_axis: tile range along one axis
// Edge, floor division by the tile, remainder fold, count division, clipping.
// ----------------------------------------------------------------------------
module vtr_axis
    import vtr_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [CoordW-1:0] center,
    input  logic [SizeW-1:0]         size,
    input  logic [CfgW-1:0]          tile,
    input  logic [CfgW-1:0]          grid,
    output axis_res_t                res
);

    logic [TwoTileW-1:0] t2;
    assign t2 = {tile, 1'b0};

    // entry stage: edge scaled by two, made positive for the divider
    logic signed [Num1W-1:0] e2;
    logic [Num1W-1:0]        n1;
    assign e2 = {{(Num1W-CoordW-1){center[CoordW-1]}}, center, 1'b0}
              - $signed({{(Num1W-SizeW){1'b0}}, size});
    assign n1 = e2[Num1W-1]
              ? Num1W'(-e2 + $signed({{(Num1W-TwoTileW){1'b0}}, t2}) - Num1W'(1))
              : Num1W'(e2);

    logic [TwoTileW-1:0] r1_reg   [0:Num1W];
    logic [Num1W-1:0]    q1_reg   [0:Num1W];
    logic                neg_reg  [0:Num1W];
    logic [SizeW-1:0]    size_reg [0:Num1W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_reg[0]   <= '0;
            q1_reg[0]   <= n1;
            neg_reg[0]  <= e2[Num1W-1];
            size_reg[0] <= size;
        end
    end

    // first divider: one quotient bit per stage
    for (genvar k = 0; k < Num1W; k++)
    begin : g_div1
        logic [TwoTileW:0]   t;
        logic                ge;
        logic [TwoTileW-1:0] r_next;
        always_comb
        begin
            t      = {r1_reg[k], q1_reg[k][Num1W-1]};
            ge     = t >= {1'b0, t2};
            r_next = ge ? TwoTileW'(t - {1'b0, t2}) : t[TwoTileW-1:0];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r1_reg[k+1]   <= r_next;
                q1_reg[k+1]   <= {q1_reg[k][Num1W-2:0], ge};
                neg_reg[k+1]  <= neg_reg[k];
                size_reg[k+1] <= size_reg[k];
            end
        end
    end

    // fixup: signed start, position inside tile, folded offset, numerator
    logic signed [StartW-1:0] start_c;
    logic [TwoTileW-1:0]      m, tm, off2;
    logic [Num2W-1:0]         n2;
    always_comb
    begin
        start_c = neg_reg[Num1W] ? -$signed({1'b0, q1_reg[Num1W]})
                                 : $signed({1'b0, q1_reg[Num1W]});
        m    = neg_reg[Num1W] ? TwoTileW'(t2 - TwoTileW'(1) - r1_reg[Num1W])
                              : r1_reg[Num1W];
        tm   = TwoTileW'(t2 - m);
        off2 = (m < tm) ? m : tm;
        n2   = {size_reg[Num1W], 1'b0} + Num2W'(off2) + Num2W'(t2) - Num2W'(1);
    end

    logic [TwoTileW-1:0]      r2_reg [0:Num2W];
    logic [Num2W-1:0]         q2_reg [0:Num2W];
    logic signed [StartW-1:0] st_reg [0:Num2W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r2_reg[0] <= '0;
            q2_reg[0] <= n2;
            st_reg[0] <= start_c;
        end
    end

    // second divider: quotient only, remainder dropped at the end
    for (genvar k = 0; k < Num2W; k++)
    begin : g_div2
        logic [TwoTileW:0]   t;
        logic                ge;
        logic [TwoTileW-1:0] r_next;
        always_comb
        begin
            t      = {r2_reg[k], q2_reg[k][Num2W-1]};
            ge     = t >= {1'b0, t2};
            r_next = ge ? TwoTileW'(t - {1'b0, t2}) : t[TwoTileW-1:0];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r2_reg[k+1] <= r_next;
                q2_reg[k+1] <= {q2_reg[k][Num2W-2:0], ge};
                st_reg[k+1] <= st_reg[k];
            end
        end
    end

    // clip A: beyond check, move a negative start to zero and shorten the count by it
    logic signed [WideW-1:0] st_w, cnt_w, g_w;
    logic signed [WideW-1:0] st1_reg, cnt1_reg;
    logic                    beyond_reg;
    always_comb
    begin
        st_w  = WideW'(st_reg[Num2W]);
        cnt_w = $signed({{(WideW-Num2W){1'b0}}, q2_reg[Num2W]});
        g_w   = $signed({{(WideW-CfgW){1'b0}}, grid});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            beyond_reg <= st_w >= g_w;
            if (st_w < 0)
            begin
                cnt1_reg <= cnt_w + st_w;
                st1_reg  <= '0;
            end
            else
            begin
                cnt1_reg <= cnt_w;
                st1_reg  <= st_w;
            end
        end
    end

    // clip B: grid edge, grid size, lower saturation
    logic signed [WideW-1:0] c2, c3, c4;
    always_comb
    begin
        c2 = (st1_reg + cnt1_reg > g_w) ? g_w - st1_reg : cnt1_reg;
        c3 = (c2 > g_w) ? g_w : c2;
        c4 = (c3 < -WideW'(65536)) ? -WideW'(65536) : c3;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res.beyond <= beyond_reg;
            res.first  <= st1_reg[CfgW-1:0];
            res.count  <= c4[CountW-1:0];
        end
    end

endmodule

// File: hw/rtl/visible_tile_range_unit.sv
// A result moves through entry, both dividers, fixup, clip and the output register.
// One request per cycle while the skid is empty; each axis runs two restoring dividers
// with one quotient bit per register stage (26 + 25 stages), which sets depth.
// A two-entry output (register plus skid) keeps intake open while one result waits.
// Reset (rst_n low, async): pipeline empty, registers to 16.0 px tiles, 64x64.
// ----------------------------------------------------------------------------
// visible_tile_range_unit: viewport to visible tile rectangle
// Computes first column/row and column/row counts of the tiles under a
// viewport given by center and size in fixed point, clipped to the grid.
// ----------------------------------------------------------------------------
module visible_tile_range_unit
    import vtr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration writes
    input  logic                wr_en,
    input  logic [1:0]          wr_index,
    input  logic [CfgW-1:0]     wr_data,
    // request stream
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // center_x[23:0], center_y[47:24], view_width[70:48], view_height[93:71]
    input  logic [95:0]         s_axis_tdata,
    // result stream
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // first_column[15:0], first_row[31:16], column_count[48:32], row_count[65:49]
    output logic [71:0]         m_axis_tdata
);

    // configuration registers
    logic [CfgW-1:0] tile_width_reg, tile_height_reg, grid_columns_reg, grid_rows_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_width_reg   <= CfgW'(4096);
            tile_height_reg  <= CfgW'(4096);
            grid_columns_reg <= CfgW'(64);
            grid_rows_reg    <= CfgW'(64);
        end
        else if (wr_en)
        begin
            unique case (cfg_index_t'(wr_index))
                REG_TILE_WIDTH:   tile_width_reg   <= wr_data;
                REG_TILE_HEIGHT:  tile_height_reg  <= wr_data;
                REG_GRID_COLUMNS: grid_columns_reg <= wr_data;
                REG_GRID_ROWS:    grid_rows_reg    <= wr_data;
                default:          ;
            endcase
        end
    end

    // The whole pipe advances unless the skid entry is occupied.
    logic skid_v_reg, out_v_reg;
    logic en;
    assign en            = !skid_v_reg;
    assign s_axis_tready = en;

    logic [AxisLat-1:0] vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[AxisLat-2:0], s_axis_tvalid};
    end

    axis_res_t res_x, res_y;

    vtr_axis u_axis_x (
        .clk    (clk),
        .en     (en),
        .center (s_axis_tdata[23:0]),
        .size   (s_axis_tdata[70:48]),
        .tile   (tile_width_reg),
        .grid   (grid_columns_reg),
        .res    (res_x)
    );

    vtr_axis u_axis_y (
        .clk    (clk),
        .en     (en),
        .center (s_axis_tdata[47:24]),
        .size   (s_axis_tdata[93:71]),
        .tile   (tile_height_reg),
        .grid   (grid_rows_reg),
        .res    (res_y)
    );

    // Drop to an all-zero rectangle on a zero tile or a start past the grid.
    logic        zero_out;
    logic [65:0] res_word;
    always_comb
    begin
        zero_out = (tile_width_reg == '0) || (tile_height_reg == '0)
                 || res_x.beyond || res_y.beyond;
        res_word = zero_out ? '0
                 : {res_y.count, res_x.count, res_y.first, res_x.first};
    end

    // output register and skid entry
    logic [65:0] out_reg, skid_reg;
    logic        out_free, pipe_out;
    assign out_free = !out_v_reg || m_axis_tready;
    assign pipe_out = vld_reg[AxisLat-1] && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (out_free)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
        end
        else if (pipe_out)
        begin
            if (out_free)
                out_v_reg <= 1'b1;
            else
                skid_v_reg <= 1'b1;
        end
        else if (out_free)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (out_free)
                out_reg <= skid_reg;
        end
        else if (pipe_out)
        begin
            if (out_free)
                out_reg <= res_word;
            else
                skid_reg <= res_word;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {6'b0, out_reg};

endmodule
